>>> rtl/core/wrml_pkg.sv
`default_nettype none

package wrml_pkg;

   // Window half length default; the ring holds twice this many samples
   localparam int HALF_WINDOW_DEF = 256;

   // Configuration reset values
   localparam logic [15:0] LOW_THR_RST  = 16'd1400;
   localparam logic [15:0] HIGH_THR_RST = 16'd3500;
   localparam logic [12:0] HOP_RST      = 13'd640;

   // Configuration register indexes
   localparam logic [1:0] CSR_LOW_THR  = 2'd0;
   localparam logic [1:0] CSR_HIGH_THR = 2'd1;
   localparam logic [1:0] CSR_HOP      = 2'd2;

   // Mouth codes
   localparam logic [1:0] MOUTH_CLOSED = 2'd0;
   localparam logic [1:0] MOUTH_OPEN   = 2'd1;
   localparam logic [1:0] MOUTH_WIDE   = 2'd2;

   // Root of a 32-bit radicand takes one result bit per step
   localparam int SQRT_STEPS = 16;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_sample;
   } req_word_type;

   typedef struct packed {
      logic [15:0] rms_value;
      logic [1:0]  mouth_level;
      logic        final_report;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] low_threshold;
      logic [15:0] high_threshold;
      logic [12:0] hop_samples;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic rd_ring;
      logic sq_old;
      logic update;
      logic div_init;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic res_load;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic report;
      logic div_last;
      logic sqrt_last;
      logic out_free;
   } dp_sts_type;

   // Square of a signed 16-bit sample; at most 2^30
   function automatic logic [30:0] square16(input logic [15:0] raw);
      logic [15:0] mag;
      logic [31:0] prod;
      begin
         mag  = raw[15] ? (16'd0 - raw) : raw;
         prod = mag * mag;
         return prod[30:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/windowed_rms_mouth_level.sv
`default_nettype none

// Channel  Ports                                   Direction  Word
// -------  --------------------------------------  ---------  ---------------------------
// req      req_valid, req_ready, req_word           in         sample, last_sample
// rsp      rsp_valid, rsp_ready, rsp_word           out        rms_value, mouth_level,
//                                                              final_report
// csr      csr_valid, csr_ready, csr_index,         in         0 low, 1 high threshold,
//          csr_wdata                                           2 hop_samples
//
// A sample without a report passes the read, square and update states before the next
// ready. A reporting sample then runs the divider and root unit, one bit per cycle;
// the window sum is SUM_W = 30 + clog2(2*HALF_WINDOW+1) bits wide.
// Reset clears the window sums, pointer, hop count and the registers to defaults;
// the ring is not cleared. A stalled rsp word holds the block in its result state
// only when a newer report is ready; no new sample is taken meanwhile.

module windowed_rms_mouth_level
   import wrml_pkg::*;
#(
   parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_word_type       rsp_word,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);

   cfg_type      cfg_ff;
   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   assign csr_ready = 1'b1;

   // Write configuration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= LOW_THR_RST;
         cfg_ff.high_threshold <= HIGH_THR_RST;
         cfg_ff.hop_samples    <= HOP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_THR:  cfg_ff.low_threshold  <= csr_wdata;
            CSR_HIGH_THR: cfg_ff.high_threshold <= csr_wdata;
            CSR_HOP:      cfg_ff.hop_samples    <= csr_wdata[12:0];
            default:      ;
         endcase
      end
   end

   wrml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   wrml_dp #(
      .HALF_WINDOW (HALF_WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

>>> rtl/core/wrml_ctrl.sv
`default_nettype none

module wrml_ctrl
   import wrml_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output ctrl_cmd_type      cmd,
   input  wire dp_sts_type   sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_SQRT_INIT,
      ST_SQRT_STEP,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid && ready_ff) state_in = ST_READ;
         ST_READ:      state_in = ST_SQUARE;
         ST_SQUARE:    state_in = ST_UPDATE;
         ST_UPDATE:    state_in = sts.report ? ST_DIV_INIT : ST_IDLE;
         ST_DIV_INIT:  state_in = ST_DIV_STEP;
         ST_DIV_STEP:  if (sts.div_last) state_in = ST_SQRT_INIT;
         ST_SQRT_INIT: state_in = ST_SQRT_STEP;
         ST_SQRT_STEP: if (sts.sqrt_last) state_in = ST_RESULT;
         ST_RESULT:    if (sts.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Hold state and the registered ready; keep ready low during reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

   // Decode datapath commands
   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == ST_IDLE) && req_valid && ready_ff;
      cmd.rd_ring   = (state_ff == ST_READ);
      cmd.sq_old    = (state_ff == ST_SQUARE);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV_STEP);
      cmd.sqrt_init = (state_ff == ST_SQRT_INIT);
      cmd.sqrt_step = (state_ff == ST_SQRT_STEP);
      cmd.res_load  = (state_ff == ST_RESULT) && sts.out_free;
   end

endmodule

`default_nettype wire

>>> rtl/core/wrml_dp.sv
`default_nettype none

module wrml_dp
   import wrml_pkg::*;
#(
   parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_word_type  req_word,
   input  wire cfg_type       cfg,
   input  wire ctrl_cmd_type  cmd,
   output dp_sts_type         sts,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_word_type       rsp_word
);

   localparam int WIN_LEN = 2 * HALF_WINDOW;
   localparam int PTR_W   = $clog2(WIN_LEN);
   localparam int CNT_W   = $clog2(WIN_LEN + 1);
   localparam int SUM_W   = 30 + CNT_W;
   localparam int IT_W    = $clog2(SUM_W);

   localparam logic [CNT_W-1:0] WIN_FULL  = CNT_W'(WIN_LEN);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WIN_LEN - 1);
   localparam logic [IT_W-1:0]  DIV_LAST  = IT_W'(SUM_W - 1);
   localparam logic [IT_W-1:0]  SQRT_LAST = IT_W'(SQRT_STEPS - 1);

   // Sample ring
   logic [15:0] ring_mem [WIN_LEN];
   logic [15:0] rd_ff;

   // Item and window state
   logic [15:0]      smp_ff;
   logic             last_ff;
   logic [30:0]      sq_new_ff;
   logic [30:0]      sq_old_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [12:0]      hop_ff, hop_in;
   logic [13:0]      hop_nx;
   logic [12:0]      hop_eff;
   logic             hop_hit;
   logic             full;

   // Divider and root
   logic [CNT_W-1:0] div_rem_ff;
   logic [SUM_W-1:0] div_q_ff;
   logic [CNT_W:0]   div_rem2;
   logic             div_ge;
   logic [IT_W-1:0]  it_ff;
   logic [31:0]      rad_ff;
   logic [17:0]      sq_rem_ff;
   logic [15:0]      root_ff;
   logic [19:0]      sq_rem2;
   logic [19:0]      sq_trial;
   logic             sq_ge;

   // Result
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;
   logic [1:0]       mouth;

   // Write new samples, read the oldest entry
   always_ff @(posedge clock) begin
      if (cmd.update) ring_mem[wp_ff] <= smp_ff;
      if (cmd.rd_ring) rd_ff <= ring_mem[wp_ff];
   end

   // Window update terms
   always_comb begin
      full    = (cnt_ff == WIN_FULL);
      sum_in  = sum_ff - (full ? SUM_W'(sq_old_ff) : '0) + SUM_W'(sq_new_ff);
      cnt_in  = full ? cnt_ff : cnt_ff + 1'b1;
      wp_in   = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
      hop_eff = (cfg.hop_samples == '0) ? 13'd1 : cfg.hop_samples;
      hop_nx  = {1'b0, hop_ff} + 14'd1;
      hop_hit = (hop_nx >= {1'b0, hop_eff});
      hop_in  = hop_hit ? '0 : hop_nx[12:0];
   end

   // Restoring division step and root step
   always_comb begin
      div_rem2 = {div_rem_ff, div_q_ff[SUM_W-1]};
      div_ge   = (div_rem2 >= {1'b0, cnt_ff});
      sq_rem2  = {sq_rem_ff, rad_ff[31:30]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_rem2 >= sq_trial);
   end

   // Pick the mouth code
   always_comb begin
      if (last_ff) mouth = MOUTH_CLOSED;
      else if (root_ff >= cfg.high_threshold) mouth = MOUTH_WIDE;
      else if (root_ff >= cfg.low_threshold) mouth = MOUTH_OPEN;
      else mouth = MOUTH_CLOSED;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         smp_ff  <= req_word.sample;
         last_ff <= req_word.last_sample;
      end
      if (cmd.rd_ring) sq_new_ff <= square16(smp_ff);
      if (cmd.sq_old) sq_old_ff <= square16(rd_ff);
      if (cmd.div_init) begin
         div_rem_ff <= '0;
         div_q_ff   <= sum_ff;
         it_ff      <= '0;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_rem2[CNT_W-1:0] - cnt_ff : div_rem2[CNT_W-1:0];
         div_q_ff   <= {div_q_ff[SUM_W-2:0], div_ge};
         it_ff      <= it_ff + 1'b1;
      end else if (cmd.sqrt_init) begin
         rad_ff    <= div_q_ff[31:0];
         sq_rem_ff <= '0;
         root_ff   <= '0;
         it_ff     <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff    <= {rad_ff[29:0], 2'b00};
         sq_rem_ff <= sq_ge ? 18'(sq_rem2 - sq_trial) : sq_rem2[17:0];
         root_ff   <= {root_ff[14:0], sq_ge};
         it_ff     <= it_ff + 1'b1;
      end
      if (cmd.res_load) begin
         rsp_word_ff.rms_value    <= root_ff;
         rsp_word_ff.mouth_level  <= mouth;
         rsp_word_ff.final_report <= last_ff;
      end
   end

   // Window state; a final report clears it
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         wp_ff  <= '0;
         hop_ff <= '0;
      end else if (cmd.res_load && last_ff) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         wp_ff  <= '0;
         hop_ff <= '0;
      end else if (cmd.update) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         hop_ff <= hop_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Status; report is read while the controller sits in the update state
   always_comb begin
      sts.report    = hop_hit || last_ff;
      sts.div_last  = (it_ff == DIV_LAST);
      sts.sqrt_last = (it_ff == SQRT_LAST);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= WIN_FULL)
      else $error("window count beyond window length");

   assert property (@(posedge clock) disable iff (reset) wp_ff <= PTR_LAST)
      else $error("write pointer beyond ring");

   assert property (@(posedge clock) disable iff (reset)
      cmd.res_load && last_ff |=> cnt_ff == '0 && sum_ff == '0 && hop_ff == '0)
      else $error("window not cleared after final report");

   assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_valid_ff && (!rsp_word_ff.final_report ||
                                         rsp_word_ff.mouth_level == MOUTH_CLOSED))
      else $error("final report with mouth not closed");

   assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> root_ff <= 16'd32768)
      else $error("rms above full scale");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import wrml_pkg::*;

   localparam int WIN_LEN       = 2 * HALF_WINDOW_DEF;
   localparam int SETTLE_CYCLES = 120;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int PLAY_BUDGET   = 400;

   // Clock, reset and block ports
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_LOW_THR;
   logic [15:0]  csr_wdata = '0;

   // Window tracker: shadow of the block's ring, sums and registers
   logic [15:0]  pcm_ring [WIN_LEN];
   logic [39:0]  power_sum = '0;
   int unsigned  fill_count = 0;
   int unsigned  ring_ptr = 0;
   int unsigned  hop_count = 0;
   logic [15:0]  low_thr = LOW_THR_RST;
   logic [15:0]  high_thr = HIGH_THR_RST;
   logic [12:0]  hop_len = HOP_RST;

   // Reports still owed by the block, oldest first
   rsp_word_type report_q[$];

   // Sender and receiver pacing
   bit           send_hot = 1'b0;
   bit           gaps_on = 1'b0;
   int           burst_left = 8;
   int           pattern_left = 0;
   logic [31:0]  stall_bits = '1;

   // Run bookkeeping
   int           miss_count = 0;
   int           sample_count = 0;
   int           report_count = 0;
   int           final_count = 0;
   int           setting_count = 0;

   windowed_rms_mouth_level uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // End the run if the block stops moving
   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Square of one signed sample, widened to the sum width
   function automatic logic [39:0] sample_power(input logic signed [15:0] s);
      longint v;
      v = s;
      return v * v;
   endfunction

   // Integer root of the integer mean, one result bit per trial
   function automatic logic [15:0] mean_root(input logic [39:0] total, input int unsigned n);
      longint unsigned radicand;
      longint unsigned trial;
      longint unsigned root;
      int b;
      radicand = total / n;
      root = 0;
      for (b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root[15:0];
   endfunction

   // Advance the window by one accepted word and queue any report it causes
   task automatic track_window(input req_word_type w);
      rsp_word_type due;
      logic [12:0]  hop_eff;
      bit           hop_done;
      hop_eff = (hop_len == 0) ? 13'd1 : hop_len;
      if (fill_count >= WIN_LEN) power_sum = power_sum - sample_power(pcm_ring[ring_ptr]);
      else fill_count++;
      pcm_ring[ring_ptr] = w.sample;
      power_sum = power_sum + sample_power(w.sample);
      ring_ptr = (ring_ptr + 1) % WIN_LEN;
      hop_count++;
      hop_done = (hop_count >= hop_eff);
      if (hop_done) hop_count = 0;
      sample_count++;
      if (hop_done || w.last_sample) begin
         due.rms_value = mean_root(power_sum, fill_count);
         if (w.last_sample) begin
            due.mouth_level  = MOUTH_CLOSED;
            due.final_report = 1'b1;
            power_sum  = '0;
            fill_count = 0;
            ring_ptr   = 0;
            hop_count  = 0;
         end else begin
            due.final_report = 1'b0;
            if (due.rms_value >= high_thr) due.mouth_level = MOUTH_WIDE;
            else if (due.rms_value >= low_thr) due.mouth_level = MOUTH_OPEN;
            else due.mouth_level = MOUTH_CLOSED;
         end
         report_q.push_back(due);
      end
   endtask

   // Send one sample word and hold it until accepted; idle between bursts
   task automatic send_sample(input logic signed [15:0] s, input logic last);
      req_word_type w;
      w.sample      = s;
      w.last_sample = last;
      req_word <= w;
      if (!send_hot) begin
         req_valid <= 1'b1;
         send_hot = 1'b1;
      end
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_window(w);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            send_hot = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // Drop valid and hold until every owed report is in, then let the block settle
   task automatic wait_reports_done;
      int waited;
      if (send_hot) begin
         req_valid <= 1'b0;
         send_hot = 1'b0;
      end
      waited = 0;
      while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (report_q.size() != 0) begin
         $display("%0t: %0d reports never arrived", $time, report_q.size());
         miss_count++;
         report_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers in one valid run; the block must be idle
   task automatic set_levels(input logic [15:0] low, input logic [15:0] high,
                             input logic [12:0] hop);
      logic [1:0]  idx [3];
      logic [15:0] val [3];
      int k;
      idx[0] = CSR_LOW_THR;
      idx[1] = CSR_HIGH_THR;
      idx[2] = CSR_HOP;
      val[0] = low;
      val[1] = high;
      val[2] = {3'd0, hop};
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      low_thr  = low;
      high_thr = high;
      hop_len  = hop;
      setting_count++;
   endtask

   // Pick a loudness for a stretch of samples
   function automatic int pick_amp;
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1500);
         1: return $urandom_range(1000, 5000);
         2: return $urandom_range(3000, 20000);
         default: return 32768;
      endcase
   endfunction

   // One sample within +/- amp, full 16-bit range at the top amplitude
   function automatic logic signed [15:0] level_sample(input int amp);
      logic [31:0] raw;
      int v;
      raw = $urandom;
      if (amp >= 32768) return raw[15:0];
      v = int'($urandom_range(0, 2 * amp)) - amp;
      return v[15:0];
   endfunction

   // Check each accepted report against the oldest owed one
   always @(posedge clock) begin : check_report
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_q.size() == 0) begin
            $display("%0t: unexpected report rms %0d mouth %0d final %0b", $time,
                     rsp_word.rms_value, rsp_word.mouth_level, rsp_word.final_report);
            miss_count++;
         end else begin
            want = report_q.pop_front();
            report_count++;
            if (want.final_report) final_count++;
            if (rsp_word.rms_value !== want.rms_value) begin
               $display("%0t: rms_value expected %0d actual %0d", $time,
                        want.rms_value, rsp_word.rms_value);
               miss_count++;
            end
            if (rsp_word.mouth_level !== want.mouth_level) begin
               $display("%0t: mouth_level expected %0d actual %0d", $time,
                        want.mouth_level, rsp_word.mouth_level);
               miss_count++;
            end
            if (rsp_word.final_report !== want.final_report) begin
               $display("%0t: final_report expected %0b actual %0b", $time,
                        want.final_report, rsp_word.final_report);
               miss_count++;
            end
         end
      end
   end

   // Stall the result side on a rotating pattern, sometimes not at all
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(50, 400);
         stall_bits = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
      end
      pattern_left--;
      stall_bits = {stall_bits[30:0], stall_bits[31]};
      rsp_ready <= stall_bits[0];
   end

   // Reset values: one regular report at the default hop, then a closing one
   task automatic test_default_levels;
      int k;
      int amp;
      gaps_on = 1'b1;
      amp = 3000;
      for (k = 0; k < 650; k++) begin
         if (k % 50 == 0) amp = pick_amp();
         send_sample(level_sample(amp), k == 649);
      end
      wait_reports_done();
   endtask

   // Zero thresholds always pass; report on every word, bit patterns at both signs
   task automatic test_zero_thresholds;
      set_levels(16'd0, 16'd0, 13'd1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd32767, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b1);
      wait_reports_done();
   endtask

   // Hop of zero reports on every word; an unreachable wide threshold
   task automatic test_zero_hop;
      set_levels(16'd200, 16'hFFFF, 13'd0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd300, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd12, 1'b0);
      send_sample(-16'sd200, 1'b1);
      wait_reports_done();
   endtask

   // Full scale root, closing report replacing a regular one, lone closing word
   task automatic test_full_scale;
      set_levels(16'd32768, 16'd32768, 13'd3);
      send_sample(-16'sd32768, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd32767, 1'b0);
      send_sample(16'sd32767, 1'b0);
      send_sample(16'sd32767, 1'b1);
      send_sample(16'sd5, 1'b1);
      wait_reports_done();
   endtask

   // Root exactly at each threshold
   task automatic test_threshold_edges;
      set_levels(16'd1000, 16'd2000, 13'd1);
      send_sample(16'sd1000, 1'b0);
      send_sample(-16'sd1000, 1'b1);
      send_sample(-16'sd2000, 1'b0);
      send_sample(16'sd1999, 1'b1);
      wait_reports_done();
   endtask

   // Largest hops: the window wraps while the hop count runs on without a report
   task automatic test_long_hop;
      int k;
      gaps_on = 1'b0;
      set_levels(16'($urandom_range(0, 6000)), 16'($urandom_range(3000, 12000)),
                 13'd4096);
      for (k = 0; k < 520; k++) send_sample(level_sample(32768), k == 519);
      wait_reports_done();
      set_levels(16'($urandom_range(0, 6000)), 16'($urandom_range(3000, 12000)),
                 13'h1FFF);
      for (k = 0; k < 40; k++) send_sample(level_sample(pick_amp()), k == 39);
      wait_reports_done();
   endtask

   // Playback runs with shifting loudness, some noise and broken runs mixed in
   task automatic test_random_playback;
      int budget;
      int r;
      int k;
      int run_len;
      int seg_left;
      int amp;
      bit well;
      logic [31:0] noise;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [12:0] hop;
      budget = 0;
      while (budget < PLAY_BUDGET) begin
         lo = 16'($urandom_range(0, 6000));
         hi = lo + 16'($urandom_range(0, 9000));
         case ($urandom_range(0, 5))
            0: lo = 16'd0;
            1: hi = 16'd32768;
            2: hi = lo;
            3: begin
               lo = 16'($urandom_range(0, 32768));
               hi = 16'($urandom_range(0, 32768));
            end
            default: ;
         endcase
         case ($urandom_range(0, 3))
            0: hop = 13'($urandom_range(1, 4));
            1: hop = 13'($urandom_range(5, 48));
            2: hop = 13'($urandom_range(100, 700));
            default: hop = 13'($urandom_range(1, 16));
         endcase
         set_levels(lo, hi, hop);
         gaps_on = ($urandom_range(0, 3) != 0);
         for (r = 0; r < 3; r++) begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(500, 800)
                                                   : $urandom_range(1, 120);
            if (run_len > PLAY_BUDGET - budget) run_len = PLAY_BUDGET - budget;
            well = ($urandom_range(0, 4) != 0);
            seg_left = 0;
            amp = 0;
            for (k = 0; k < run_len; k++) begin
               if (seg_left == 0) begin
                  amp = pick_amp();
                  seg_left = $urandom_range(8, 64);
               end
               seg_left--;
               if (well) begin
                  send_sample(level_sample(amp), k == run_len - 1);
               end else begin
                  noise = $urandom;
                  send_sample(noise[15:0], $urandom_range(0, 60) == 0);
               end
               budget++;
            end
         end
         // hold off until every report of this setting is in
         wait_reports_done();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_levels();
      test_zero_thresholds();
      test_zero_hop();
      test_full_scale();
      test_threshold_edges();
      test_random_playback();
      test_long_hop();
      wait_reports_done();
      $display("Covered %0d samples under %0d register settings,", sample_count,
               setting_count);
      $display("checking %0d level reports of which %0d closed playback.", report_count,
               final_count);
      if (miss_count == 0 && report_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
